@@ hw/rtl/bounded_double_ended_queue_unit_defines.svh @@
// Assertion macros shared by the queue checker.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define BDQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bdq_pkg.sv @@
// Package: operation and status codes and fixed field widths of the queue.
package bdq_pkg;

    localparam int OP_W     = 3;
    localparam int ITEM_IO_W = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ_NTH   = 3'd4,
        OP_CLEAR      = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

@@ hw/rtl/bdq_if.sv @@
// Interfaces: request and response channels of the queue.
interface bdq_req_if import bdq_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [ITEM_IO_W-1:0] item_in;
    logic [POS_W-1:0]     position;

    modport source (output valid, output op, output item_in, output position, input ready);
    modport sink   (input valid, input op, input item_in, input position, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [ITEM_IO_W-1:0] item_out;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   count;

    modport source (output valid, output item_out, output status, output count, input ready);
    modport sink   (input valid, input item_out, input status, input count, output ready);
endinterface

@@ hw/rtl/bounded_double_ended_queue_unit.sv @@
// Bounded double-ended queue of item words held in a ring-buffer memory.
// Requests arrive on i_req (op, item_in, position); every request gives one
// response on o_rsp (item_out, status, count), in request order.
// Ops: push back/front, pop back/front, read nth from the front, clear.
// A push when full is dropped with status full; a pop when empty or a read
// beyond the fill count gives status empty and a zero item.
// Latency: the response is valid in the cycle after the request transaction.
// Throughput: one request per cycle while the receiver is ready; head pointer
// and count update in the accepting cycle, and the slot memory (one write port,
// one registered read port) is written or read in that same cycle.
// The response sits in an output register; while the receiver stalls it is
// held, and a new request is taken in the cycle the old response leaves.
// Reset (synchronous, active low) empties the queue and drops any pending
// response; slot contents are not cleared and need not be.
module bounded_double_ended_queue_unit
    import bdq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bdq_req_if.sink      i_req,
    bdq_rsp_if.source    o_rsp
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Slot memory
    logic [ITEM_WIDTH-1:0] r_mem [DEPTH];
    logic [ITEM_WIDTH-1:0] r_rdata;

    logic [PW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic            r_out_valid;
    t_status         r_status, n_status;
    logic            r_rd_ok, n_rd_ok;

    logic            w_acc;
    logic            w_we;
    logic [PW-1:0]   w_waddr;
    logic [PW-1:0]   w_raddr;
    logic [63:0]     w_in64;
    logic [63:0]     w_rd64;
    logic [31:0]     w_pos32;
    logic [31:0]     w_cnt32;
    logic            w_full;
    logic            w_empty;

    // Ring index: head plus offset, folded once below DEPTH
    function automatic logic [PW-1:0] wrap_add(input logic [SW-1:0] a,
                                               input logic [SW-1:0] b);
        logic [SW-1:0] s;
        s = a + b;
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[PW-1:0];
    endfunction

    assign w_acc   = i_req.valid & i_req.ready;
    assign w_full  = (r_count == DEPTH_C);
    assign w_empty = (r_count == '0);
    assign w_in64  = 64'(i_req.item_in);
    assign w_pos32 = 32'(i_req.position);
    assign w_cnt32 = 32'(r_count);

    // Operation decode: pointer update, memory port control, status
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        n_rd_ok  = 1'b0;
        w_we     = 1'b0;
        w_waddr  = wrap_add(SW'(r_head), SW'(r_count));
        w_raddr  = r_head;
        case (i_req.op)
            OP_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_head  = wrap_add(SW'(r_head), DEPTH_S - 1'b1);
                    w_waddr = n_head;
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_raddr = wrap_add(SW'(r_head), SW'(r_count - 1'b1));
                    n_rd_ok = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_rd_ok = 1'b1;
                    n_head  = wrap_add(SW'(r_head), SW'(1));
                    n_count = r_count - 1'b1;
                end
            end
            OP_READ_NTH: begin
                if (w_pos32 >= w_cnt32) begin
                    n_status = ST_EMPTY;
                end else begin
                    // position is below the count here, so it fits SW bits
                    w_raddr = wrap_add(SW'(r_head), w_pos32[SW-1:0]);
                    n_rd_ok = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_head  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Control state and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
        end
    end

    // Memory: one write, one registered read per transaction
    always_ff @(posedge i_clk) begin
        if (w_acc && w_we) begin
            r_mem[w_waddr] <= w_in64[ITEM_WIDTH-1:0];
        end
        if (w_acc) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // Output side
    assign w_rd64         = 64'(r_rdata);
    assign i_req.ready    = ~r_out_valid | o_rsp.ready;
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.item_out = r_rd_ok ? w_rd64[ITEM_IO_W-1:0] : '0;
    assign o_rsp.status   = r_status;
    assign o_rsp.count    = w_cnt32[COUNT_W-1:0];

endmodule

@@ hw/rtl/bdq_checker.sv @@
// Checker: port-level properties of the queue, bound to the top level.
`include "bounded_double_ended_queue_unit_defines.svh"

module bdq_checker
    import bdq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_req_valid,
    input logic                 i_req_ready,
    input logic [OP_W-1:0]      i_req_op,
    input logic                 i_rsp_valid,
    input logic [ITEM_IO_W-1:0] i_rsp_item_out,
    input logic [STATUS_W-1:0]  i_rsp_status,
    input logic [COUNT_W-1:0]   i_rsp_count
);

    logic w_acc;
    assign w_acc = i_req_valid & i_req_ready;

    // Every request transaction is answered in the next cycle
    `BDQ_ASSERT_NEXT(a_rsp_follows, i_clk, i_rst_n, w_acc, i_rsp_valid,
        "response missing after request")

    // A clear leaves an empty queue and a zero ok response
    `BDQ_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, w_acc && (i_req_op == OP_CLEAR),
        i_rsp_valid && (i_rsp_count == '0) && (i_rsp_status == ST_OK) &&
        (i_rsp_item_out == '0), "clear did not empty queue")

    // An empty or out-of-range response carries no item
    `BDQ_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n,
        i_rsp_valid && (i_rsp_status == ST_EMPTY), i_rsp_item_out == '0,
        "item on empty status")

    // A dropped push is reported only at full occupancy
    `BDQ_ASSERT_SAME(a_full_count, i_clk, i_rst_n,
        i_rsp_valid && (i_rsp_status == ST_FULL),
        (i_rsp_count == COUNT_W'(DEPTH)) && (i_rsp_item_out == '0),
        "full status below capacity")

endmodule

bind bounded_double_ended_queue_unit bdq_checker #(
    .DEPTH (DEPTH)
) u_bdq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_req_op       (i_req.op),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_item_out (o_rsp.item_out),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_count    (o_rsp.count)
);

@@ tb/tb_bounded_double_ended_queue_unit.sv @@
`timescale 1ns / 1ps
// Testbench for the bounded double-ended queue unit: directed table, then random traffic vs a deque predictor.
module tb_bounded_double_ended_queue_unit;
    import bdq_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int N_RANDOM    = 1950;
    localparam int QUIET_TAIL  = 250;

    // Op codes outside the defined set; the queue must treat them as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY, MIX_READ} t_mix;

    typedef struct packed {
        logic [ITEM_IO_W-1:0] item;
        t_status              status;
        logic [COUNT_W-1:0]   count;
    } t_rsp;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [ITEM_IO_W-1:0] item;
        logic [POS_W-1:0]     pos;
        logic                 fixed;
        t_rsp                 exp;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    bdq_req_if req_ch();
    bdq_rsp_if rsp_ch();

    bounded_double_ended_queue_unit #(
        .DEPTH      (QUEUE_DEPTH),
        .ITEM_WIDTH (ITEM_IO_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the deque state
    logic [ITEM_IO_W-1:0] shadow_slots [QUEUE_DEPTH];
    logic [POS_W-1:0]     shadow_head;
    logic [COUNT_W-1:0]   shadow_fill;

    t_rsp awaited_rsps[$];
    int   mismatch_count;
    bit   sender_bursty;
    bit   quiet_tail;

    // Clock: 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Apply one request to the shadow state and return the response it should give
    function automatic t_rsp predict_response(input logic [OP_W-1:0] op,
                                              input logic [ITEM_IO_W-1:0] item,
                                              input logic [POS_W-1:0] pos);
        t_rsp             r;
        logic [POS_W-1:0] idx;
        r.item   = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_BACK: begin
                if (shadow_fill >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    idx = shadow_head + shadow_fill[POS_W-1:0];
                    shadow_slots[idx] = item;
                    shadow_fill++;
                end
            end
            OP_PUSH_FRONT: begin
                if (shadow_fill >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_head = shadow_head - 1'b1;
                    shadow_slots[shadow_head] = item;
                    shadow_fill++;
                end
            end
            OP_POP_BACK: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // fill of 64 wraps to 0 in the low bits, so head - 1 is the tail
                    idx = shadow_head + shadow_fill[POS_W-1:0] - 1'b1;
                    r.item = shadow_slots[idx];
                    shadow_fill--;
                end
            end
            OP_POP_FRONT: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.item = shadow_slots[shadow_head];
                    shadow_head = shadow_head + 1'b1;
                    shadow_fill--;
                end
            end
            OP_READ_NTH: begin
                if ({1'b0, pos} >= shadow_fill) begin
                    r.status = ST_EMPTY;
                end else begin
                    idx = shadow_head + pos;
                    r.item = shadow_slots[idx];
                end
            end
            OP_CLEAR: begin
                shadow_head = '0;
                shadow_fill = '0;
            end
            default: begin
            end
        endcase
        r.count = shadow_fill;
        return r;
    endfunction

    // Present one request, hold it until the transaction, then log its expected response
    task automatic issue_request(input logic [OP_W-1:0] op, input logic [ITEM_IO_W-1:0] item,
                                 input logic [POS_W-1:0] pos, input logic fixed,
                                 input t_rsp fixed_rsp);
        t_rsp model_rsp;
        if (sender_bursty && !quiet_tail && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.item_in  <= item;
        req_ch.position <= pos;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        model_rsp = predict_response(op, item, pos);
        awaited_rsps.push_back(fixed ? fixed_rsp : model_rsp);
    endtask

    // Hold off the sender until every outstanding response is back
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_rsps.size() != 0);
    endtask

    // Response checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (awaited_rsps.size() == 0) begin
                $error("response with none awaited: item_out %h status %0d count %0d",
                       rsp_ch.item_out, rsp_ch.status, rsp_ch.count);
                mismatch_count++;
            end else begin
                want = awaited_rsps.pop_front();
                if (rsp_ch.item_out !== want.item) begin
                    $error("item_out: expected %h, got %h", want.item, rsp_ch.item_out);
                    mismatch_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    mismatch_count++;
                end
                if (rsp_ch.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver: random stall bursts, none in the tail
    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Stimulus
    initial begin
        t_row                 dir_rows[$];
        t_mix                 mix;
        int                   n_rand;
        int                   span;
        int                   pick;
        int                   push_pct;
        bit                   first_chunk;
        logic [OP_W-1:0]      op;
        logic [OP_W-1:0]      push_op;
        logic [OP_W-1:0]      pop_op;
        logic [ITEM_IO_W-1:0] item;
        logic [POS_W-1:0]     pos;

        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.op       <= OP_CLEAR;
        req_ch.item_in  <= '0;
        req_ch.position <= '0;
        shadow_head     = '0;
        shadow_fill     = '0;
        mismatch_count  = 0;
        sender_bursty   = 1'b1;
        quiet_tail      = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue, extremes, both ends, out-of-range reads, spare ops,
        // clear, and a front push wrapping the head below slot zero
        dir_rows.push_back('{OP_POP_BACK,   32'h0,        6'd0,  1'b1, '{32'h0, ST_EMPTY, 7'd0}});
        dir_rows.push_back('{OP_POP_FRONT,  32'h0,        6'd0,  1'b1, '{32'h0, ST_EMPTY, 7'd0}});
        dir_rows.push_back('{OP_READ_NTH,   32'h0,        6'd0,  1'b1, '{32'h0, ST_EMPTY, 7'd0}});
        dir_rows.push_back('{OP_PUSH_BACK,  32'hFFFFFFFF, 6'd0,  1'b1, '{32'h0, ST_OK,    7'd1}});
        dir_rows.push_back('{OP_PUSH_FRONT, 32'h00000000, 6'd63, 1'b1, '{32'h0, ST_OK,    7'd2}});
        dir_rows.push_back('{OP_PUSH_BACK,  32'hA5A5A5A5, 6'd0,  1'b1, '{32'h0, ST_OK,    7'd3}});
        dir_rows.push_back('{OP_PUSH_FRONT, 32'h5A5A5A5A, 6'd0,  1'b1, '{32'h0, ST_OK,    7'd4}});
        dir_rows.push_back('{OP_READ_NTH,   32'h0,        6'd0,  1'b0, '0});
        dir_rows.push_back('{OP_READ_NTH,   32'h0,        6'd3,  1'b0, '0});
        dir_rows.push_back('{OP_READ_NTH,   32'h0,        6'd4,  1'b1, '{32'h0, ST_EMPTY, 7'd4}});
        dir_rows.push_back('{OP_READ_NTH,   32'h0,        6'd63, 1'b1, '{32'h0, ST_EMPTY, 7'd4}});
        dir_rows.push_back('{OP_SPARE_A,    32'hFFFFFFFF, 6'd63, 1'b1, '{32'h0, ST_OK,    7'd4}});
        dir_rows.push_back('{OP_SPARE_B,    32'hFFFFFFFF, 6'd63, 1'b1, '{32'h0, ST_OK,    7'd4}});
        dir_rows.push_back('{OP_POP_FRONT,  32'h0,        6'd0,  1'b0, '0});
        dir_rows.push_back('{OP_POP_BACK,   32'h0,        6'd0,  1'b0, '0});
        dir_rows.push_back('{OP_CLEAR,      32'hFFFFFFFF, 6'd0,  1'b1, '{32'h0, ST_OK,    7'd0}});
        dir_rows.push_back('{OP_POP_FRONT,  32'h0,        6'd0,  1'b1, '{32'h0, ST_EMPTY, 7'd0}});
        dir_rows.push_back('{OP_PUSH_FRONT, 32'h12345678, 6'd0,  1'b1, '{32'h0, ST_OK,    7'd1}});
        dir_rows.push_back('{OP_PUSH_FRONT, 32'h9ABCDEF0, 6'd0,  1'b1, '{32'h0, ST_OK,    7'd2}});
        dir_rows.push_back('{OP_POP_BACK,   32'h0,        6'd0,  1'b0, '0});
        dir_rows.push_back('{OP_POP_BACK,   32'h0,        6'd0,  1'b0, '0});
        dir_rows.push_back('{OP_POP_BACK,   32'h0,        6'd0,  1'b1, '{32'h0, ST_EMPTY, 7'd0}});

        foreach (dir_rows[i])
            issue_request(dir_rows[i].op, dir_rows[i].item, dir_rows[i].pos,
                          dir_rows[i].fixed, dir_rows[i].exp);
        wait_for_drain();

        // Random traffic in chunks; the first chunk fills the queue past full
        first_chunk = 1'b1;
        n_rand      = 0;
        while (n_rand < N_RANDOM) begin
            mix           = first_chunk ? MIX_FILL : t_mix'($urandom_range(0, 3));
            push_pct      = first_chunk ? 100 : 85;
            first_chunk   = 1'b0;
            sender_bursty = 1'($urandom_range(0, 1));
            case (mix)
                MIX_FILL:  span = QUEUE_DEPTH - shadow_fill + $urandom_range(4, 16);
                MIX_DRAIN: span = shadow_fill + $urandom_range(4, 16);
                MIX_READ:  span = $urandom_range(10, 40);
                default:   span = $urandom_range(20, 60);
            endcase

            repeat (span) begin
                if (n_rand >= N_RANDOM - QUIET_TAIL)
                    quiet_tail = 1'b1;
                pick    = $urandom_range(0, 99);
                push_op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                pop_op  = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
                case (mix)
                    MIX_FILL:
                        op = (pick < push_pct) ? push_op : ((pick < 95) ? pop_op : OP_READ_NTH);
                    MIX_DRAIN:
                        op = (pick < push_pct) ? pop_op : ((pick < 95) ? push_op : OP_READ_NTH);
                    MIX_READ:
                        op = (pick < 80) ? OP_READ_NTH : ((pick < 90) ? push_op : pop_op);
                    default: begin
                        if (pick < 40)      op = push_op;
                        else if (pick < 75) op = pop_op;
                        else if (pick < 93) op = OP_READ_NTH;
                        else if (pick < 96) op = OP_CLEAR;
                        else if (pick < 98) op = OP_SPARE_A;
                        else                op = OP_SPARE_B;
                    end
                endcase

                // mostly in-range positions, the rest anywhere
                if (op == OP_READ_NTH && shadow_fill != 0 && $urandom_range(0, 3) != 0)
                    pos = POS_W'($urandom_range(0, shadow_fill - 1));
                else
                    pos = POS_W'($urandom);

                case ($urandom_range(0, 15))
                    0:       item = '0;
                    1:       item = '1;
                    default: item = $urandom;
                endcase

                issue_request(op, item, pos, 1'b0, '0);
                n_rand++;
                if (n_rand >= N_RANDOM)
                    break;
            end

            if (!quiet_tail && $urandom_range(0, 4) == 0)
                wait_for_drain();
        end

        // Wind down: collect every response, then allow for the pipeline
        wait_for_drain();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ bounded_double_ended_queue_unit.f @@
+incdir+hw/rtl
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_if.sv
hw/rtl/bounded_double_ended_queue_unit.sv
hw/rtl/bdq_checker.sv
tb/tb_bounded_double_ended_queue_unit.sv
